// ===== hdl/pfrid_pkg.sv =====
package pfrid_pkg;

	localparam int unsigned DEPTH    = 16;
	localparam int unsigned OCC_W    = $clog2(DEPTH + 1);
	localparam int unsigned PID_W    = 16;
	localparam int unsigned PAY_W    = 48;
	localparam int unsigned COUNT_W  = 5;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned IN_W     = PID_W + PAY_W;
	localparam int unsigned OUT_W    = 1 + PID_W + PAY_W + COUNT_W + 1 + 1;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_REM = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic [PAY_W-1:0] payload;
		logic [PID_W-1:0] pid;
	} rec_t;

	typedef struct packed {
		logic cap;
		logic exe;
		op_t  op;
	} ctl_t;

endpackage

// ===== hdl/pfrid_cell.sv =====
module pfrid_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfrid_pkg::ctl_t               ctl,
	input  logic [pfrid_pkg::PID_W-1:0]   cmp_pid,
	input  pfrid_pkg::rec_t               wr_rec,
	input  logic                          head,
	input  logic                          left_valid,
	input  logic                          right_valid,
	input  pfrid_pkg::rec_t               right_rec,
	input  logic                          hit_in,
	output logic                          hit_out,
	input  pfrid_pkg::rec_t               sel_in,
	output pfrid_pkg::rec_t               sel_out,
	output logic                          valid,
	output pfrid_pkg::rec_t               rec
);

	logic            valid_q;
	logic            hit_q;
	pfrid_pkg::rec_t rec_q;
	logic            hit_d;
	logic            taken;
	logic            shift;
	logic            ld_enq;

	always_comb begin
		hit_d = 1'b0;
		case (ctl.op)
			pfrid_pkg::OP_DEQ: hit_d = head & valid_q;
			pfrid_pkg::OP_REM: hit_d = valid_q & (rec_q.pid == cmp_pid);
			default:           hit_d = 1'b0;
		endcase
	end

	assign taken   = hit_q & ~hit_in;
	assign hit_out = hit_in | hit_q;
	assign shift   = ctl.exe & hit_out;
	assign ld_enq  = ctl.exe & (ctl.op == pfrid_pkg::OP_ENQ) & ~valid_q & left_valid;
	assign sel_out = sel_in | (taken ? rec_q : pfrid_pkg::rec_t'('0));
	assign valid   = valid_q;
	assign rec     = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			if (ctl.cap) begin
				hit_q <= hit_d;
			end else if (ctl.exe) begin
				hit_q <= 1'b0;
			end
			if (shift) begin
				valid_q <= right_valid;
			end else if (ld_enq) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			rec_q <= right_rec;
		end else if (ld_enq) begin
			rec_q <= wr_rec;
		end
	end

endmodule

// ===== hdl/process_fifo_with_remove_by_id_top.sv =====
// Process record queue with removal by process id.
// The input stream carries one command per transfer: tuser holds the opcode
// (enqueue, dequeue, or remove by id) and tdata holds the id and the payload.
// The output stream returns exactly one result per command with the removed
// record, a found flag, the occupancy after the command, a not-empty flag,
// and a dropped flag for an enqueue refused by a full queue.
// Records live in a row of sixteen cells, head first; every cell compares its
// own id in parallel and a removal closes the gap by a one-step shift toward
// the head.
// For each command, the accepting edge captures the compare results in the
// cells, and the execute state then performs the shift or the write and
// loads the result register. tready is low in the execute state, so a new
// command is accepted only after the current one has executed.
// When the receiver stalls, the result is held in the output register and a
// further command may be accepted, but it is not executed until the held
// result has been taken.
// Reset empties the queue and clears the output valid.
module process_fifo_with_remove_by_id_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// pid[15:0], payload[63:16]
	input  logic [pfrid_pkg::IN_W-1:0]    s_axis_tdata,
	// opcode[1:0]
	input  logic [pfrid_pkg::OP_W-1:0]    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// found[0], out_pid[16:1], out_payload[64:17], count[69:65],
	// not_empty[70], dropped[71]
	output logic [pfrid_pkg::OUT_W-1:0]   m_axis_tdata
);

	localparam int unsigned N = pfrid_pkg::DEPTH;

	pfrid_pkg::state_t                state_q;
	pfrid_pkg::state_t                state_d;
	pfrid_pkg::op_t                   op_q;
	pfrid_pkg::rec_t                  wr_rec_q;
	logic [pfrid_pkg::OCC_W-1:0]      occ_q;
	logic [pfrid_pkg::OCC_W-1:0]      occ_d;
	logic                             m_tvalid_q;
	logic [pfrid_pkg::OUT_W-1:0]      m_tdata_q;

	logic                             cap;
	logic                             exe;
	logic                             out_free;
	logic                             full;
	logic                             drop;
	logic                             found;
	pfrid_pkg::ctl_t                  ctl;
	pfrid_pkg::rec_t                  in_rec;

	logic                             valid_w [N];
	pfrid_pkg::rec_t                  rec_w   [N];
	logic                             hit_c   [N+1];
	pfrid_pkg::rec_t                  sel_c   [N+1];

	assign in_rec.pid     = s_axis_tdata[pfrid_pkg::PID_W-1:0];
	assign in_rec.payload = s_axis_tdata[pfrid_pkg::IN_W-1:pfrid_pkg::PID_W];

	assign out_free = ~m_tvalid_q | m_axis_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pfrid_pkg::ST_IDLE: if (s_axis_tvalid) state_d = pfrid_pkg::ST_EXEC;
			pfrid_pkg::ST_EXEC: if (out_free) state_d = pfrid_pkg::ST_IDLE;
			default:            state_d = pfrid_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		exe           = 1'b0;
		case (state_q)
			pfrid_pkg::ST_IDLE: s_axis_tready = 1'b1;
			pfrid_pkg::ST_EXEC: exe = out_free;
			default: begin
				s_axis_tready = 1'b0;
				exe           = 1'b0;
			end
		endcase
	end

	assign cap     = s_axis_tvalid & s_axis_tready;
	assign ctl.cap = cap;
	assign ctl.exe = exe;
	assign ctl.op  = cap ? pfrid_pkg::op_t'(s_axis_tuser) : op_q;

	assign hit_c[0] = 1'b0;
	assign sel_c[0] = pfrid_pkg::rec_t'('0);

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic            left_v;
		logic            right_v;
		pfrid_pkg::rec_t right_r;
		if (i == 0) begin : g_head
			assign left_v = 1'b1;
		end else begin : g_body
			assign left_v = valid_w[i-1];
		end
		if (i == N - 1) begin : g_tail
			assign right_v = 1'b0;
			assign right_r = pfrid_pkg::rec_t'('0);
		end else begin : g_mid
			assign right_v = valid_w[i+1];
			assign right_r = rec_w[i+1];
		end
		pfrid_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.cmp_pid     (in_rec.pid),
			.wr_rec      (wr_rec_q),
			.head        ((i == 0) ? 1'b1 : 1'b0),
			.left_valid  (left_v),
			.right_valid (right_v),
			.right_rec   (right_r),
			.hit_in      (hit_c[i]),
			.hit_out     (hit_c[i+1]),
			.sel_in      (sel_c[i]),
			.sel_out     (sel_c[i+1]),
			.valid       (valid_w[i]),
			.rec         (rec_w[i])
		);
	end

	assign found = hit_c[N];
	assign full  = (occ_q == pfrid_pkg::OCC_W'(N));
	assign drop  = (op_q == pfrid_pkg::OP_ENQ) & full;

	always_comb begin
		occ_d = occ_q;
		if ((op_q == pfrid_pkg::OP_ENQ) && !full) begin
			occ_d = occ_q + pfrid_pkg::OCC_W'(1);
		end else if (found) begin
			occ_d = occ_q - pfrid_pkg::OCC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pfrid_pkg::ST_IDLE;
			occ_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (exe) begin
				occ_q      <= occ_d;
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			op_q     <= pfrid_pkg::op_t'(s_axis_tuser);
			wr_rec_q <= in_rec;
		end
		if (exe) begin
			m_tdata_q <= {drop, (occ_d != '0), pfrid_pkg::COUNT_W'(occ_d),
				sel_c[N].payload, sel_c[N].pid, found};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

endmodule

// ===== hdl/pfrid_chk.sv =====
module pfrid_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [pfrid_pkg::OUT_W-1:0]   m_axis_tdata
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("Input accepted again in the execute cycle.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("Stalled result changed or vanished.");

	a_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[70] == (m_axis_tdata[69:65] != 5'd0)))
		else $error("Not-empty flag disagrees with count.");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[71] |->
			!m_axis_tdata[0] &&
			(m_axis_tdata[69:65] == pfrid_pkg::COUNT_W'(pfrid_pkg::DEPTH)))
		else $error("Dropped enqueue reported without a full queue.");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[64:1] == 64'd0))
		else $error("Record fields not zero on a miss.");

endmodule

bind process_fifo_with_remove_by_id_top pfrid_chk u_pfrid_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
